// ----- design/pdr_pkg.sv -----
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared widths and constants for the perceptual deadband reducer.
// ----------------------------------------------------------------------------
package pdr_pkg;
  localparam int Channels   = 7;
  localparam int SampleBits = 16;
  localparam int DiffBits   = SampleBits + 1;
  localparam int SqBits     = 2 * DiffBits;
  localparam int SumBits    = SqBits + 3;
  localparam int RatioFrac  = 12;
  localparam int NumBits    = SumBits + 2 * RatioFrac;
  localparam int RatioBits  = 16;
  localparam logic [SampleBits-1:0] LastReset = SampleBits'(2560);
  localparam logic [RatioBits-1:0]  ThreshReset = RatioBits'(410);
  localparam logic [RatioBits-1:0]  RatioMax = '1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [SqBits-1:0] sq_t;
endpackage

// ----- design/pdr_lane.sv -----
// ----------------------------------------------------------------------------
// pdr_lane
// One channel lane: registered squared difference and squared last value.
// ----------------------------------------------------------------------------
module pdr_lane import pdr_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  sample_t cur_i,
  input  sample_t last_i,
  output sq_t     d_sq_o,
  output sq_t     p_sq_o
);
  logic signed [DiffBits-1:0] diff;
  logic [DiffBits-1:0] ad, ap;
  sq_t d_sq_q, p_sq_q;

  always_comb begin
    diff = DiffBits'(cur_i) - DiffBits'(last_i);
    ad   = diff[DiffBits-1] ? DiffBits'(-diff) : DiffBits'(diff);
    ap   = last_i[SampleBits-1] ? DiffBits'(-DiffBits'(last_i)) : DiffBits'(last_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_sq_q <= ad * ad;
      p_sq_q <= ap * ap;
    end
  end

  assign d_sq_o = d_sq_q;
  assign p_sq_o = p_sq_q;
endmodule

// ----- design/pdr_ratio.sv -----
// ----------------------------------------------------------------------------
// pdr_ratio
// Merge of lane sums, then bit-serial divide and bit-serial square root.
// ----------------------------------------------------------------------------
module pdr_ratio import pdr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sq_t [Channels-1:0]   d_sq_i,
  input  sq_t [Channels-1:0]   p_sq_i,
  output logic                 done_o,
  output logic [RatioBits-1:0] ratio_o
);
  typedef enum logic [2:0] {S_IDLE, S_SUM, S_DIV, S_SQRT, S_DONE} state_e;
  localparam int CntBits = $clog2(NumBits + 1);
  localparam int RootBits = NumBits / 2 + 1;

  state_e               state_q;
  logic [CntBits-1:0]   cnt_q;
  logic [SumBits-1:0]   d2_q, p2_q;
  logic [NumBits-1:0]   quo_q;
  logic [SumBits:0]     rem_q;
  logic [NumBits+1:0]   sn_q;
  logic [RootBits+1:0]  res_q, bit_q;
  logic [RatioBits-1:0] ratio_q;
  logic                 done_q;
  logic [SumBits-1:0]   d2_sum, p2_sum;
  logic [SumBits:0]     rem_sh;
  logic [NumBits+1:0]   trial;

  always_comb begin
    d2_sum = '0;
    p2_sum = '0;
    for (int i = 0; i < Channels; i++) begin
      d2_sum = d2_sum + SumBits'(d_sq_i[i]);
      p2_sum = p2_sum + SumBits'(p_sq_i[i]);
    end
    rem_sh = {rem_q[SumBits-1:0], quo_q[NumBits-1]};
    trial  = (NumBits+2)'(res_q) + (NumBits+2)'(bit_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start_i) state_q <= S_SUM;
        S_SUM: begin
          d2_q  <= d2_sum;
          p2_q  <= p2_sum;
          quo_q <= {d2_sum, (2*RatioFrac)'(0)};
          rem_q <= '0;
          cnt_q <= CntBits'(NumBits);
          state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (p2_q == '0) begin
            ratio_q <= (d2_q == '0) ? '0 : RatioMax;
            done_q  <= 1'b1;
            state_q <= S_DONE;
          end else if (cnt_q == '0) begin
            sn_q  <= (NumBits+2)'(quo_q);
            res_q <= '0;
            bit_q <= (RootBits+2)'(1) << (2 * (RootBits / 2));
            state_q <= S_SQRT;
          end else begin
            if (rem_sh >= {1'b0, p2_q}) begin
              rem_q <= rem_sh - {1'b0, p2_q};
              quo_q <= {quo_q[NumBits-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[NumBits-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_SQRT: begin
          // digit-by-digit root, two radicand bits per cycle
          if (bit_q == '0) begin
            ratio_q <= (res_q > (RootBits+2)'(RatioMax)) ? RatioMax : RatioBits'(res_q);
            done_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            if (sn_q >= trial) begin
              sn_q  <= sn_q - trial;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign ratio_o = ratio_q;
endmodule

// ----- design/perceptual_deadband_reducer.sv -----
// ----------------------------------------------------------------------------
// perceptual_deadband_reducer
// Deadband data reducer with zero-order hold over a seven-channel vector.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i / in_stall_o | sample_0_i .. sample_6_i
//  out     | out_valid_o / out_stall_i | held_*_o, transmit_o, change_ratio_o
//  cfg     | cfg_we_i               | cfg_wdata_i (deadband threshold)
//
// one item at a time: the input stalls until the result lands in the output register;
// the steps are lane squares, sum, bit-serial divider, bit-serial square root and
// the result register
// zero last magnitude skips divide and root
// reset loads the last sent vector with 2560 per channel, threshold 410
// a waiting result does not stall the input: the next item is taken and held
// until the output register frees up, then its compute starts
// ----------------------------------------------------------------------------
module perceptual_deadband_reducer import pdr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sample_t               sample_0_i, sample_1_i, sample_2_i, sample_3_i,
  input  sample_t               sample_4_i, sample_5_i, sample_6_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sample_t               held_0_o, held_1_o, held_2_o, held_3_o,
  output sample_t               held_4_o, held_5_o, held_6_o,
  output logic                  transmit_o,
  output logic [RatioBits-1:0]  change_ratio_o,
  input  logic                  cfg_we_i,
  input  logic [RatioBits-1:0]  cfg_wdata_i
);
  sample_t [Channels-1:0] cur_q, last_q, held_q, in_vec;
  sq_t     [Channels-1:0] d_sq, p_sq;
  logic [RatioBits-1:0]   thresh_q, ratio, ratio_out_q;
  logic busy_q, lane_go_q, wait_q, go, done, ovalid_q, tx_q, send;

  assign in_vec = {sample_6_i, sample_5_i, sample_4_i, sample_3_i,
                   sample_2_i, sample_1_i, sample_0_i};

  // busy from accept until the item's result lands in the output register
  // (the last vector must be settled before the next item uses it)
  assign in_stall_o = busy_q;
  wire in_acc = in_valid_i && !in_stall_o;

  // start the lanes only when the output register can take the result
  assign go = (in_acc || wait_q) && !(ovalid_q && out_stall_i);

  for (genvar g = 0; g < Channels; g++) begin : g_lane
    pdr_lane u_lane (
      .clk_i, .en_i(lane_go_q), .cur_i(cur_q[g]), .last_i(last_q[g]),
      .d_sq_o(d_sq[g]), .p_sq_o(p_sq[g])
    );
  end

  pdr_ratio u_ratio (
    .clk_i, .rst_ni, .start_i(lane_go_q), .d_sq_i(d_sq), .p_sq_i(p_sq),
    .done_o(done), .ratio_o(ratio)
  );

  assign send = ratio >= thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      lane_go_q <= 1'b0;
      wait_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      thresh_q  <= ThreshReset;
      for (int i = 0; i < Channels; i++) last_q[i] <= LastReset;
    end else begin
      lane_go_q <= go;
      wait_q    <= (in_acc || wait_q) && !go;
      if (cfg_we_i) thresh_q <= cfg_wdata_i;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (in_acc) begin
        cur_q  <= in_vec;
        busy_q <= 1'b1;
      end
      if (done) begin
        busy_q      <= 1'b0;
        ovalid_q    <= 1'b1;
        tx_q        <= send;
        ratio_out_q <= ratio;
        held_q      <= send ? cur_q : last_q;
        if (send) last_q <= cur_q;
      end
    end
  end

  assign out_valid_o    = ovalid_q;
  assign transmit_o     = tx_q;
  assign change_ratio_o = ratio_out_q;
  assign held_0_o = held_q[0];
  assign held_1_o = held_q[1];
  assign held_2_o = held_q[2];
  assign held_3_o = held_q[3];
  assign held_4_o = held_q[4];
  assign held_5_o = held_q[5];
  assign held_6_o = held_q[6];
endmodule
